@@ design/llmq_pkg.sv @@
`timescale 1ns / 1ps

package llmq_pkg;

    // Fixed port widths
    localparam int QID_W = 3;
    localparam int ENT_W = 6;
    localparam int REQ_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TAIL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_HEAD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QRD,
        ST_TAIL2,
        ST_XRD
    } t_state;

    // Queue table write controls
    typedef struct packed {
        logic head_we;
        logic tail_we;
        logic set_empty;
        logic clr_empty;
    } t_qtab_wr;

    // Link memory write controls
    typedef struct packed {
        logic we;
        logic is_null;
    } t_link_wr;

endpackage

@@ design/llmq_qtab.sv @@
`timescale 1ns / 1ps

module llmq_qtab #(
    parameter int NUM_QUEUES = 8,
    parameter int QW         = 3,
    parameter int EW         = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [QW-1:0]     i_rd_addr,
    input  logic [QW-1:0]     i_q_addr,
    input  llmq_pkg::t_qtab_wr i_wr,
    input  logic [EW-1:0]     i_head,
    input  logic [EW-1:0]     i_tail,
    output logic [EW-1:0]     o_head,
    output logic [EW-1:0]     o_tail,
    output logic              o_empty
);
    import llmq_pkg::*;

    logic [EW-1:0] r_head_mem [NUM_QUEUES];
    logic [EW-1:0] r_tail_mem [NUM_QUEUES];
    logic [EW-1:0] r_head_rd;
    logic [EW-1:0] r_tail_rd;
    logic [NUM_QUEUES-1:0] r_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr.head_we) begin
            r_head_mem[i_q_addr] <= i_head;
        end
        if (i_rd_en) begin
            r_head_rd <= r_head_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.tail_we) begin
            r_tail_mem[i_q_addr] <= i_tail;
        end
        if (i_rd_en) begin
            r_tail_rd <= r_tail_mem[i_rd_addr];
        end
    end

    // empty flags are flops so reset marks every queue empty at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= '1;
        end else if (i_wr.set_empty) begin
            r_empty[i_q_addr] <= 1'b1;
        end else if (i_wr.clr_empty) begin
            r_empty[i_q_addr] <= 1'b0;
        end
    end

    assign o_head  = r_head_rd;
    assign o_tail  = r_tail_rd;
    assign o_empty = r_empty[i_q_addr];

endmodule

@@ design/llmq_link.sv @@
`timescale 1ns / 1ps

module llmq_link #(
    parameter int NUM_ENTRIES = 64,
    parameter int EW          = 6
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [EW-1:0]     i_rd_addr,
    input  llmq_pkg::t_link_wr i_wr,
    input  logic [EW-1:0]     i_wr_addr,
    input  logic [EW-1:0]     i_wr_link,
    output logic [EW-1:0]     o_link,
    output logic              o_null
);
    import llmq_pkg::*;

    // word = {null flag, next link}; link is don't-care while null is set
    logic [EW:0] r_mem [NUM_ENTRIES];
    logic [EW:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr_addr] <= {i_wr.is_null, i_wr_link};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_null = r_rd[EW];
    assign o_link = r_rd[EW-1:0];

endmodule

@@ design/linked_list_multi_queue_core.sv @@
// Result: the strobe rises as the request leaves ST_QRD for inserts at the head, inserts
//   into an empty queue, extracts from an empty queue and ignored requests; as it leaves
//   ST_TAIL2 or ST_XRD for inserts at the tail of a non-empty queue and found extracts.
// Requests: one at a time; a new request is accepted only in ST_IDLE, so the queue table
//   read and the link memory read that may follow it within a request never overlap another.
// Reset: synchronous, active low; all queues empty, no result pending. Results cannot stall.
`timescale 1ns / 1ps

module linked_list_multi_queue_core #(
    parameter int NUM_ENTRIES = 64,
    parameter int NUM_QUEUES  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [llmq_pkg::REQ_W-1:0]  i_req_type,
    input  logic [llmq_pkg::QID_W-1:0]  i_queue_id,
    input  logic [llmq_pkg::ENT_W-1:0]  i_entry_index,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [llmq_pkg::ENT_W-1:0]  o_popped_entry,
    output logic                        o_now_empty
);
    import llmq_pkg::*;

    localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int EW   = $clog2(NUM_ENTRIES);
    // compare widths: wide enough for the port field, the index and the bound
    localparam int QC_W = ((QW > QID_W) ? QW : QID_W) + 1;
    localparam int EC_W = ((EW > ENT_W) ? EW : ENT_W) + 1;

    t_state r_state, n_state;

    // request beat, captured at accept
    logic [REQ_W-1:0] r_req;
    logic [QW-1:0]    r_q;
    logic [EW-1:0]    r_e;
    logic             r_q_ok;
    logic             r_e_ok;

    // result register
    logic             r_valid, n_valid;
    logic             r_found, n_found;
    logic [ENT_W-1:0] r_popped, n_popped;
    logic             r_now_empty, n_now_empty;

    logic [QC_W-1:0]  q_ext;
    logic [EC_W-1:0]  e_ext;
    logic             accept;

    // memory-side signals
    logic             qt_rd_en;
    t_qtab_wr         qt_wr;
    logic [EW-1:0]    qt_head_wd;
    logic [EW-1:0]    qt_tail_wd;
    logic [EW-1:0]    qt_head;
    logic [EW-1:0]    qt_tail;
    logic             qt_empty;

    logic             lk_rd_en;
    t_link_wr         lk_wr;
    logic [EW-1:0]    lk_wr_addr;
    logic [EW-1:0]    lk_wr_link;
    logic [EW-1:0]    lk_link;
    logic             lk_null;

    assign q_ext  = QC_W'(i_queue_id);
    assign e_ext  = EC_W'(i_entry_index);
    assign accept = start && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_q    <= q_ext[QW-1:0];
            r_e    <= e_ext[EW-1:0];
            r_q_ok <= (q_ext < QC_W'(NUM_QUEUES));
            r_e_ok <= (e_ext < EC_W'(NUM_ENTRIES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found     <= n_found;
        r_popped    <= n_popped;
        r_now_empty <= n_now_empty;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_QRD;
                end
            end
            ST_QRD: begin
                n_state = ST_IDLE;
                if (r_q_ok) begin
                    if (r_req == REQ_TAIL && r_e_ok && !qt_empty) begin
                        n_state = ST_TAIL2;
                    end else if (r_req == REQ_POP && !qt_empty) begin
                        n_state = ST_XRD;
                    end
                end
            end
            ST_TAIL2: n_state = ST_IDLE;
            ST_XRD:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory controls and result
    always_comb begin
        busy        = (r_state != ST_IDLE);
        qt_rd_en    = accept;
        qt_wr       = '0;
        qt_head_wd  = r_e;
        qt_tail_wd  = r_e;
        lk_rd_en    = 1'b0;
        lk_wr       = '0;
        lk_wr_addr  = r_e;
        lk_wr_link  = qt_head;
        n_valid     = 1'b0;
        n_found     = 1'b0;
        n_popped    = '0;
        n_now_empty = qt_empty;

        unique case (r_state)
            ST_IDLE: begin
            end
            ST_QRD: begin
                if (!r_q_ok) begin
                    n_valid     = 1'b1;
                    n_now_empty = 1'b1;
                end else begin
                    unique case (r_req)
                        REQ_TAIL: begin
                            if (r_e_ok) begin
                                qt_wr.tail_we   = 1'b1;
                                qt_wr.clr_empty = 1'b1;
                                lk_wr.we        = 1'b1;
                                if (qt_empty) begin
                                    // first entry: it is both head and tail
                                    qt_wr.head_we = 1'b1;
                                    lk_wr.is_null = 1'b1;
                                    n_valid       = 1'b1;
                                    n_now_empty   = 1'b0;
                                end else begin
                                    // old tail now links to the new entry
                                    lk_wr_addr = qt_tail;
                                    lk_wr_link = r_e;
                                end
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        REQ_HEAD: begin
                            if (r_e_ok) begin
                                qt_wr.head_we   = 1'b1;
                                qt_wr.tail_we   = qt_empty;
                                qt_wr.clr_empty = 1'b1;
                                lk_wr.we        = 1'b1;
                                lk_wr.is_null   = qt_empty;
                                n_now_empty     = 1'b0;
                            end
                            n_valid = 1'b1;
                        end
                        REQ_POP: begin
                            if (qt_empty) begin
                                n_valid = 1'b1;
                            end else begin
                                lk_rd_en = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_TAIL2: begin
                // new tail terminates the list
                lk_wr.we      = 1'b1;
                lk_wr.is_null = 1'b1;
                n_valid       = 1'b1;
                n_now_empty   = 1'b0;
            end
            ST_XRD: begin
                qt_head_wd      = lk_link;
                qt_wr.head_we   = !lk_null;
                qt_wr.set_empty = lk_null;
                n_valid         = 1'b1;
                n_found         = 1'b1;
                n_popped        = ENT_W'(qt_head);
                n_now_empty     = lk_null;
            end
            default: begin
            end
        endcase
    end

    llmq_qtab #(
        .NUM_QUEUES (NUM_QUEUES),
        .QW         (QW),
        .EW         (EW)
    ) u_qtab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (qt_rd_en),
        .i_rd_addr (q_ext[QW-1:0]),
        .i_q_addr  (r_q),
        .i_wr      (qt_wr),
        .i_head    (qt_head_wd),
        .i_tail    (qt_tail_wd),
        .o_head    (qt_head),
        .o_tail    (qt_tail),
        .o_empty   (qt_empty)
    );

    llmq_link #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .EW          (EW)
    ) u_link (
        .i_clk     (i_clk),
        .i_rd_en   (lk_rd_en),
        .i_rd_addr (qt_head),
        .i_wr      (lk_wr),
        .i_wr_addr (lk_wr_addr),
        .i_wr_link (lk_wr_link),
        .o_link    (lk_link),
        .o_null    (lk_null)
    );

    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_popped_entry = r_popped;
    assign o_now_empty    = r_now_empty;

endmodule

@@ design/llmq_checker.sv @@
`timescale 1ns / 1ps

module llmq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic                       o_found,
    input logic [llmq_pkg::ENT_W-1:0] o_popped_entry
);
    import llmq_pkg::*;

    // an accepted beat keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    // the result strobe comes exactly when busy drops
    a_fall_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_popped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_popped_entry == '0)
        else $error("popped entry nonzero without found");

endmodule

bind linked_list_multi_queue_core llmq_checker u_llmq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_found        (o_found),
    .o_popped_entry (o_popped_entry)
);

@@ tb/linked_list_multi_queue_core_test.sv @@
`timescale 1ns / 1ps

module linked_list_multi_queue_core_test;
    import llmq_pkg::*;

    localparam int NQ = 8;
    localparam int NE = 64;
    // request code 3 is unused by the block: no state change
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
    localparam int RAND_BEATS = 1350;
    // margin left after the last result before the run ends
    localparam int TAIL_CYCLES = 8;

    // one result beat: what the block reports for a request
    typedef struct packed {
        logic             found;
        logic [ENT_W-1:0] popped;
        logic             now_empty;
    } t_outcome;

    // Shadow copy of the queue tables and link memory, plus the FIFO of
    // outcomes still owed by the block. Updated at each accepted request,
    // drained at each result strobe.
    class QueueShadow;
        logic [ENT_W-1:0] head_of[NQ];
        logic [ENT_W-1:0] tail_of[NQ];
        bit               empty_q[NQ];
        logic [ENT_W-1:0] link_of[NE];
        bit               link_null[NE];
        t_outcome         owed[$];
        int               mismatches;

        function new();
            foreach (empty_q[i]) empty_q[i] = 1'b1;
            mismatches = 0;
        endfunction

        function t_outcome note_request(logic [REQ_W-1:0] req, logic [QID_W-1:0] q,
                                        logic [ENT_W-1:0] e);
            t_outcome res;
            res = '0;
            case (req)
                REQ_TAIL: begin
                    // old tail links to the new entry; order matters when e == tail
                    if (!empty_q[q]) begin
                        link_of[tail_of[q]]   = e;
                        link_null[tail_of[q]] = 1'b0;
                    end else begin
                        head_of[q] = e;
                    end
                    tail_of[q]   = e;
                    link_null[e] = 1'b1;
                    empty_q[q]   = 1'b0;
                end
                REQ_HEAD: begin
                    if (!empty_q[q]) begin
                        link_of[e]   = head_of[q];
                        link_null[e] = 1'b0;
                    end else begin
                        link_null[e] = 1'b1;
                        tail_of[q]   = e;
                    end
                    head_of[q] = e;
                    empty_q[q] = 1'b0;
                end
                REQ_POP: begin
                    if (!empty_q[q]) begin
                        res.found  = 1'b1;
                        res.popped = head_of[q];
                        if (link_null[head_of[q]])
                            empty_q[q] = 1'b1;
                        else
                            head_of[q] = link_of[head_of[q]];
                    end
                end
                default: ;
            endcase
            res.now_empty = empty_q[q];
            owed.push_back(res);
            return res;
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing owed: found=%0d popped=%0d empty=%0d",
                             $realtime, got.found, got.popped, got.now_empty);
                return;
            end
            want = owed.pop_front();
            if (got.found !== want.found || got.popped !== want.popped ||
                got.now_empty !== want.now_empty) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch found %0d/%0d popped %0d/%0d empty %0d/%0d (exp/act)",
                             $realtime, want.found, got.found, want.popped, got.popped,
                             want.now_empty, got.now_empty);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic [REQ_W-1:0] req_type;
    logic [QID_W-1:0] queue_id;
    logic [ENT_W-1:0] entry_index;
    wire              busy;
    wire              o_valid;
    wire              o_found;
    wire  [ENT_W-1:0] o_popped_entry;
    wire              o_now_empty;

    QueueShadow shadow;
    // stimulus-side view of which slots sit in some queue; only steers the
    // generator toward legal inserts, the shadow above is what gets checked
    bit in_queue[NE];

    linked_list_multi_queue_core #(
        .NUM_ENTRIES(NE),
        .NUM_QUEUES (NQ)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (req_type),
        .i_queue_id    (queue_id),
        .i_entry_index (entry_index),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_popped_entry(o_popped_entry),
        .o_now_empty   (o_now_empty)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side: the block cannot be stalled, so every strobe is a beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            shadow.check_result('{o_found, o_popped_entry, o_now_empty});
    end

    // Send one request. Inputs move on the falling edge; start stays high
    // from the previous beat when there is no gap, so it is never dropped
    // and raised in the same step.
    task automatic issue(input logic [REQ_W-1:0] r, input logic [QID_W-1:0] q,
                         input logic [ENT_W-1:0] e, input int gap);
        t_outcome res;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_type    <= r;
        queue_id    <= q;
        entry_index <= e;
        start       <= 1'b1;
        // busy read here is its value just before the edge: accept when low
        do @(posedge i_clk); while (busy !== 1'b0);
        res = shadow.note_request(r, q, e);
        if (res.found)
            in_queue[res.popped] = 1'b0;
        if (r == REQ_TAIL || r == REQ_HEAD)
            in_queue[e] = 1'b1;
    endtask

    // random slot not currently queued, or -1 when the pool is used up
    function automatic int pick_free();
        int base;
        base = $urandom_range(0, NE - 1);
        for (int k = 0; k < NE; k++)
            if (!in_queue[(base + k) % NE])
                return (base + k) % NE;
        return -1;
    endfunction

    initial begin
        int gap;
        int roll;
        int slot;
        logic [QID_W-1:0] q;
        shadow      = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        req_type    = REQ_TAIL;
        queue_id    = '0;
        entry_index = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pop on empty, tail/head inserts with slot extremes,
        // unused code on non-empty and empty queues, repeated insert of the tail
        issue(REQ_POP,  3'd0, 6'd63, 0);
        issue(REQ_TAIL, 3'd0, 6'd0,  0);
        issue(REQ_TAIL, 3'd0, 6'd63, 0);
        issue(REQ_HEAD, 3'd0, 6'd21, 0);
        issue(REQ_NONE, 3'd0, 6'd42, 0);
        issue(REQ_NONE, 3'd3, 6'd0,  0);
        issue(REQ_HEAD, 3'd7, 6'd42, 0);
        issue(REQ_TAIL, 3'd7, 6'd1,  0);
        issue(REQ_POP,  3'd0, 6'd0,  0);
        issue(REQ_POP,  3'd0, 6'd0,  0);
        issue(REQ_POP,  3'd0, 6'd0,  0);
        issue(REQ_POP,  3'd0, 6'd0,  0);
        issue(REQ_TAIL, 3'd5, 6'd10, 0);
        issue(REQ_TAIL, 3'd5, 6'd10, 0);
        issue(REQ_POP,  3'd5, 6'd0,  0);
        issue(REQ_HEAD, 3'd2, 6'd63, 3);
        issue(REQ_POP,  3'd7, 6'd0,  1);
        issue(REQ_POP,  3'd7, 6'd0,  0);
        issue(REQ_POP,  3'd7, 6'd0,  2);
        issue(REQ_POP,  3'd2, 6'd0,  0);

        // random: mostly legal inserts of free slots and pops; a few
        // unused codes and re-inserts of slots that may already be queued
        for (int n = 0; n < RAND_BEATS; n++) begin
            gap  = ((n % 120) < 30) ? 0 : $urandom_range(0, 14);
            q    = QID_W'($urandom_range(0, NQ - 1));
            roll = $urandom_range(0, 99);
            slot = pick_free();
            if (roll < 3)
                issue(REQ_NONE, q, ENT_W'($urandom_range(0, NE - 1)), gap);
            else if (roll < 6)
                issue((roll % 2) ? REQ_TAIL : REQ_HEAD, q,
                      ENT_W'($urandom_range(0, NE - 1)), gap);
            else if (roll < 55 && slot >= 0)
                issue($urandom_range(0, 1) ? REQ_TAIL : REQ_HEAD, q, ENT_W'(slot), gap);
            else
                issue(REQ_POP, q, ENT_W'($urandom_range(0, NE - 1)), gap);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (shadow.owed.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (shadow.mismatches == 0)
            $display("linked_list_multi_queue_core_test: done, clean");
        else
            $display("linked_list_multi_queue_core_test: done, errors");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("linked_list_multi_queue_core_test: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
design/llmq_pkg.sv
design/llmq_qtab.sv
design/llmq_link.sv
design/linked_list_multi_queue_core.sv
design/llmq_checker.sv
tb/linked_list_multi_queue_core_test.sv
